### rtl/core/rational_arithmetic_unit_defines.svh
// Assertion macros for the rational arithmetic unit.
// Included by files that check their own logic; needs clk and arst_n in scope.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define RAU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rau check failed");

// next-cycle implication
`define RAU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rau check failed");

`endif

### rtl/core/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
// No dependencies.
`default_nettype none
package rau_pkg;

	localparam int unsigned OPW    = 32;
	localparam int unsigned MAGW   = 31;
	localparam int unsigned PRODW  = 62;
	localparam int unsigned WORDW  = 64;
	localparam int unsigned DENW   = 62;
	localparam int unsigned SHW    = 6;
	localparam int unsigned CNTW   = 6;

	localparam logic [OPW-1:0] MIN_INT = {1'b1, {(OPW-1){1'b0}}};

	typedef enum logic [2:0] {
		ACT_ADD = 3'd0,
		ACT_SUB = 3'd1,
		ACT_MUL = 3'd2,
		ACT_DIV = 3'd3,
		ACT_CMP = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_SUM,
		ST_GCD,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} cmd_t;

	typedef struct packed {
		logic signed [63:0] res_num;
		logic [61:0]        res_den;
		logic               is_equal;
		logic               is_not_equal;
		logic               is_greater;
		logic               is_less;
		logic               error;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic fin;
	} div_ctl_t;

endpackage
`default_nettype wire

### rtl/core/rational_arithmetic_unit.sv
// Rational arithmetic unit top level: add, subtract, multiply, divide, compare.
// Depends on rau_pkg, rau_divider (and rau_cell), rational_arithmetic_unit_defines.svh.
//
//  channel   | handshake       | payload
//  ----------+-----------------+-----------------------------
//  command   | start / busy    | cmd (action, a_num .. b_den)
//  result    | done (strobe)   | rsp (res_num .. error)
//
// A bad command (zero denominator, most-negative operand, unused code, divide by zero)
// returns its error beat in the cycle after acceptance; compare and zero results
// come out of ST_MUL1, ST_MUL2, ST_MUL3 and ST_SUM; other operations then run the
// binary GCD loop and the two serial dividers before their beat.
// Reset clears the sequencer; the receiver cannot stall, so done lasts one cycle.
`default_nettype none
`include "rational_arithmetic_unit_defines.svh"
module rational_arithmetic_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire rau_pkg::cmd_t cmd,
	output logic               done,
	output rau_pkg::rsp_t      rsp
);

	rau_pkg::state_t state_q, state_d;

	// operand magnitudes and signs, captured at acceptance
	logic [rau_pkg::MAGW-1:0]  an_q, ad_q, bn_q, bd_q;
	logic                      sa_q, sb_q;
	logic [2:0]                act_q;

	logic [rau_pkg::PRODW-1:0] prod_q, p1_q, p2_q;
	logic [rau_pkg::MAGW-1:0]  mx, my;
	logic [rau_pkg::PRODW-1:0] prod_d;

	logic [rau_pkg::WORDW-1:0] ga_q, gb_q;
	logic [rau_pkg::SHW-1:0]   k_q;
	logic                      neg_q;
	logic [rau_pkg::WORDW-1:0] gcd_val;
	logic [rau_pkg::WORDW-1:0] nmag, nmag_q;

	logic                      bad;
	logic                      accept;
	logic [rau_pkg::WORDW-1:0] v1, v2, nsum;
	logic                      s1, use_p2;

	rau_pkg::div_ctl_t         dctl;
	logic                      fin_d;
	logic [rau_pkg::WORDW-1:0] qn, qd;

	rau_pkg::rsp_t             rsp_q, rsp_d;
	logic                      done_q;

	function automatic logic [rau_pkg::MAGW-1:0] mag(input logic [rau_pkg::OPW-1:0] x);
		logic [rau_pkg::OPW-1:0] t;
		t = x[rau_pkg::OPW-1] ? (~x + 1'b1) : x;
		return t[rau_pkg::MAGW-1:0];
	endfunction

	// reject anything the datapath cannot carry
	always_comb begin
		bad = 1'b0;
		if (!(cmd.action inside {rau_pkg::ACT_ADD, rau_pkg::ACT_SUB, rau_pkg::ACT_MUL,
				rau_pkg::ACT_DIV, rau_pkg::ACT_CMP})) begin
			bad = 1'b1;
		end
		if (cmd.a_den == '0 || cmd.b_den == '0) begin
			bad = 1'b1;
		end
		if (cmd.a_num == rau_pkg::MIN_INT || cmd.a_den == rau_pkg::MIN_INT ||
				cmd.b_num == rau_pkg::MIN_INT || cmd.b_den == rau_pkg::MIN_INT) begin
			bad = 1'b1;
		end
		if (cmd.action == rau_pkg::ACT_DIV && cmd.b_num == '0) begin
			bad = 1'b1;
		end
	end

	assign accept = start && !busy;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rau_pkg::ST_IDLE: begin
				if (accept && !bad) state_d = rau_pkg::ST_MUL1;
			end
			rau_pkg::ST_MUL1: state_d = rau_pkg::ST_MUL2;
			rau_pkg::ST_MUL2: state_d = rau_pkg::ST_MUL3;
			rau_pkg::ST_MUL3: state_d = rau_pkg::ST_SUM;
			rau_pkg::ST_SUM: begin
				if (act_q == rau_pkg::ACT_CMP || nsum == '0) state_d = rau_pkg::ST_IDLE;
				else                                           state_d = rau_pkg::ST_GCD;
			end
			rau_pkg::ST_GCD: begin
				if (ga_q == '0) state_d = rau_pkg::ST_DIV;
			end
			rau_pkg::ST_DIV: begin
				if (fin_d) state_d = rau_pkg::ST_IDLE;
			end
			default: state_d = rau_pkg::ST_IDLE;
		endcase
	end

	// state outputs: handshake, multiplier operand selection and divider load
	always_comb begin
		busy      = 1'b1;
		mx        = an_q;
		my        = bd_q;
		dctl.load = 1'b0;
		case (state_q)
			rau_pkg::ST_IDLE: busy = 1'b0;
			rau_pkg::ST_MUL1: begin
				mx = an_q;
				my = (act_q == rau_pkg::ACT_MUL) ? bn_q : bd_q;
			end
			rau_pkg::ST_MUL2: begin
				mx = bn_q;
				my = ad_q;
			end
			rau_pkg::ST_MUL3: begin
				mx = ad_q;
				my = (act_q == rau_pkg::ACT_DIV) ? bn_q : bd_q;
			end
			rau_pkg::ST_GCD: dctl.load = (ga_q == '0);
			default: ;
		endcase
	end

	assign prod_d = mx * my;

	// sign handling: multiply and divide fold both signs into the first product
	assign s1     = sa_q ^ ((act_q == rau_pkg::ACT_MUL || act_q == rau_pkg::ACT_DIV) ? sb_q : 1'b0);
	assign use_p2 = !(act_q == rau_pkg::ACT_MUL || act_q == rau_pkg::ACT_DIV);
	assign v1     = s1 ? ('0 - {2'b00, p1_q}) : {2'b00, p1_q};
	assign v2     = !use_p2 ? '0 : (sb_q ? ('0 - {2'b00, p2_q}) : {2'b00, p2_q});
	assign nsum   = (act_q == rau_pkg::ACT_SUB) ? (v1 - v2) : (v1 + v2);
	assign nmag   = nsum[rau_pkg::WORDW-1] ? ('0 - nsum) : nsum;

	assign gcd_val = gb_q << k_q;

	// beat contents for the state that produces one
	always_comb begin
		rsp_d = '0;
		case (state_q)
			rau_pkg::ST_IDLE: rsp_d.error = 1'b1;
			rau_pkg::ST_SUM: begin
				if (act_q == rau_pkg::ACT_CMP) begin
					rsp_d.is_equal     = (v1 == v2);
					rsp_d.is_not_equal = (v1 != v2);
					rsp_d.is_greater   = ($signed(v1) > $signed(v2));
					rsp_d.is_less      = ($signed(v1) < $signed(v2));
				end else if (nsum == '0) begin
					rsp_d.res_den = rau_pkg::DENW'(1);
				end
			end
			rau_pkg::ST_DIV: begin
				rsp_d.res_num = neg_q ? ('0 - qn) : qn;
				rsp_d.res_den = qd[rau_pkg::DENW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rau_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == rau_pkg::ST_IDLE && accept && bad) ||
				(state_q == rau_pkg::ST_SUM && (act_q == rau_pkg::ACT_CMP || nsum == '0)) ||
				(state_q == rau_pkg::ST_DIV && fin_d);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			rau_pkg::ST_IDLE: begin
				an_q  <= mag(cmd.a_num);
				ad_q  <= mag(cmd.a_den);
				bn_q  <= mag(cmd.b_num);
				bd_q  <= mag(cmd.b_den);
				sa_q  <= cmd.a_num[rau_pkg::OPW-1] ^ cmd.a_den[rau_pkg::OPW-1];
				sb_q  <= cmd.b_num[rau_pkg::OPW-1] ^ cmd.b_den[rau_pkg::OPW-1];
				act_q <= cmd.action;
				if (accept && bad) begin
					rsp_q <= rsp_d;
				end
			end
			rau_pkg::ST_MUL1: prod_q <= prod_d;
			rau_pkg::ST_MUL2: begin
				p1_q   <= prod_q;
				prod_q <= prod_d;
			end
			rau_pkg::ST_MUL3: begin
				p2_q   <= prod_q;
				prod_q <= prod_d;
			end
			rau_pkg::ST_SUM: begin
				rsp_q  <= rsp_d;
				// hold the numerator magnitude for the divider, the GCD loop eats ga_q
				nmag_q <= nmag;
				ga_q   <= nmag;
				gb_q   <= {2'b00, prod_q};
				k_q    <= '0;
				neg_q  <= nsum[rau_pkg::WORDW-1];
			end
			rau_pkg::ST_GCD: begin
				// binary GCD: halve evens, subtract odds and halve the difference
				if (ga_q != '0) begin
					if (!ga_q[0] && !gb_q[0]) begin
						ga_q <= ga_q >> 1;
						gb_q <= gb_q >> 1;
						k_q  <= k_q + 1'b1;
					end else if (!ga_q[0]) begin
						ga_q <= ga_q >> 1;
					end else if (!gb_q[0]) begin
						gb_q <= gb_q >> 1;
					end else if (ga_q >= gb_q) begin
						ga_q <= (ga_q - gb_q) >> 1;
					end else begin
						gb_q <= (gb_q - ga_q) >> 1;
					end
				end
			end
			rau_pkg::ST_DIV: begin
				if (fin_d) begin
					rsp_q <= rsp_d;
				end
			end
			default: ;
		endcase
	end

	// two dividers share the divisor: one for the numerator, one for the denominator
	rau_divider u_div_num (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (dctl.load),
		.dividend (nmag_q),
		.divisor  (gcd_val),
		.fin      (dctl.fin),
		.quotient (qn)
	);

	rau_divider u_div_den (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (dctl.load),
		.dividend ({2'b00, prod_q}),
		.divisor  (gcd_val),
		.fin      (fin_d),
		.quotient (qd)
	);

	assign done = done_q;
	assign rsp  = rsp_q;

	// an error beat carries nothing else
	`RAU_ASSERT_NOW(a_err_clean, done && rsp.error, rsp.res_den == '0 && rsp.res_num == '0)
	// a compare beat gives exactly one ordering and a consistent inequality flag
	`RAU_ASSERT_NOW(a_cmp_flags, done && !rsp.error && rsp.res_den == '0,
		$onehot({rsp.is_equal, rsp.is_greater, rsp.is_less}) && rsp.is_not_equal != rsp.is_equal)
	// a good command keeps the unit busy
	`RAU_ASSERT_NEXT(a_busy_after, start && !busy && !bad, busy)
	// both dividers finish together
	`RAU_ASSERT_NOW(a_div_sync, dctl.fin || fin_d, dctl.fin && fin_d)

endmodule
`default_nettype wire

### rtl/core/rau_cell.sv
// One bit cell of the dividend/quotient chain.
// Uses no package items.
`default_nettype none
module rau_cell (
	input  wire logic clk,
	input  wire logic load,
	input  wire logic shift,
	input  wire logic load_bit,
	input  wire logic shift_in,
	output logic      bit_q
);

	always_ff @(posedge clk) begin
		if (load) begin
			bit_q <= load_bit;
		end else if (shift) begin
			bit_q <= shift_in;
		end
	end

endmodule
`default_nettype wire

### rtl/core/rau_divider.sv
// Bit-serial restoring divider built on a chain of rau_cell bit cells.
// Depends on rau_pkg and rau_cell.
`default_nettype none
module rau_divider (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       load,
	input  wire logic [rau_pkg::WORDW-1:0]  dividend,
	input  wire logic [rau_pkg::WORDW-1:0]  divisor,
	output logic                            fin,
	output logic [rau_pkg::WORDW-1:0]       quotient
);

	logic [rau_pkg::WORDW-1:0] chain;
	logic [rau_pkg::WORDW-1:0] rem_q;
	logic [rau_pkg::WORDW-1:0] dsr_q;
	logic [rau_pkg::CNTW-1:0]  cnt_q;
	logic                      run_q;
	logic                      fin_q;
	logic [rau_pkg::WORDW:0]   rem_ext;
	logic [rau_pkg::WORDW:0]   trial;
	logic                      ge;

	assign rem_ext = {rem_q, chain[rau_pkg::WORDW-1]};
	assign trial   = rem_ext - {1'b0, dsr_q};
	assign ge      = rem_ext >= {1'b0, dsr_q};

	// quotient bits enter at the bottom as dividend bits leave at the top
	for (genvar i = 0; i < rau_pkg::WORDW; i++) begin : g_chain
		rau_cell u_cell (
			.clk      (clk),
			.load     (load),
			.shift    (run_q),
			.load_bit (dividend[i]),
			.shift_in ((i == 0) ? ge : chain[(i == 0) ? 0 : i-1]),
			.bit_q    (chain[i])
		);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? trial[rau_pkg::WORDW-1:0] : rem_ext[rau_pkg::WORDW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			run_q <= 1'b0;
			fin_q <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			if (load) begin
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	assign fin      = fin_q;
	assign quotient = chain;

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Testbench for the rational arithmetic unit: directed and random fraction commands.
// Depends on rau_pkg and rational_arithmetic_unit; a scoreboard class predicts each result and checks the done beats.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

	// Predicts reduced fractions and compare flags, holds them in order.
	class fraction_scoreboard;
		rau_pkg::rsp_t pending_q[$];
		int            fail_cnt;

		function longint unsigned gcd_of(longint unsigned p, longint unsigned q);
			while (p != 0 && q != 0) begin
				if (p > q)
					p = p % q;
				else
					q = q % p;
			end
			return p + q;
		endfunction

		function rau_pkg::rsp_t predict(rau_pkg::cmd_t c);
			rau_pkg::rsp_t r;
			longint an, ad, bn, bd, n, d, l, rr, g;
			r = '0;
			an = c.a_num;
			ad = c.a_den;
			bn = c.b_num;
			bd = c.b_den;
			if (c.action > rau_pkg::ACT_CMP || ad == 0 || bd == 0 ||
				c.a_num == rau_pkg::MIN_INT || c.a_den == rau_pkg::MIN_INT ||
				c.b_num == rau_pkg::MIN_INT || c.b_den == rau_pkg::MIN_INT ||
				(c.action == rau_pkg::ACT_DIV && bn == 0)) begin
				r.error = 1'b1;
				return r;
			end
			// normalise denominators to positive
			if (ad < 0) begin ad = -ad; an = -an; end
			if (bd < 0) begin bd = -bd; bn = -bn; end
			if (c.action == rau_pkg::ACT_CMP) begin
				l = an * bd;
				rr = bn * ad;
				r.is_equal = (l == rr);
				r.is_not_equal = (l != rr);
				r.is_greater = (l > rr);
				r.is_less = (l < rr);
				return r;
			end
			case (c.action)
				rau_pkg::ACT_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
				rau_pkg::ACT_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
				rau_pkg::ACT_MUL: begin n = an * bn; d = ad * bd; end
				default: begin
					n = an * bd;
					d = ad * bn;
					if (d < 0) begin d = -d; n = -n; end
				end
			endcase
			if (n == 0)
				d = 1;
			else begin
				g = gcd_of((n < 0) ? -n : n, d);
				n = n / g;
				d = d / g;
			end
			r.res_num = n;
			r.res_den = d[61:0];
			return r;
		endfunction

		function void note_command(rau_pkg::cmd_t c);
			pending_q.push_back(predict(c));
		endfunction

		function void check_result(rau_pkg::rsp_t got);
			rau_pkg::rsp_t exp_r;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				fail_cnt++;
				return;
			end
			exp_r = pending_q.pop_front();
			if (got.res_num !== exp_r.res_num)
				$display("%0t: res_num exp %0d got %0d", $time, exp_r.res_num, got.res_num);
			if (got.res_den !== exp_r.res_den)
				$display("%0t: res_den exp %0d got %0d", $time, exp_r.res_den, got.res_den);
			if (got.is_equal !== exp_r.is_equal)
				$display("%0t: is_equal exp %b got %b", $time, exp_r.is_equal, got.is_equal);
			if (got.is_not_equal !== exp_r.is_not_equal)
				$display("%0t: is_not_equal exp %b got %b", $time, exp_r.is_not_equal,
					got.is_not_equal);
			if (got.is_greater !== exp_r.is_greater)
				$display("%0t: is_greater exp %b got %b", $time, exp_r.is_greater,
					got.is_greater);
			if (got.is_less !== exp_r.is_less)
				$display("%0t: is_less exp %b got %b", $time, exp_r.is_less, got.is_less);
			if (got.error !== exp_r.error)
				$display("%0t: error exp %b got %b", $time, exp_r.error, got.error);
			if (got !== exp_r)
				fail_cnt++;
		endfunction
	endclass

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	logic           busy;
	logic           done;
	rau_pkg::cmd_t  cmd = '0;
	rau_pkg::rsp_t  rsp;

	fraction_scoreboard fsb = new();

	rational_arithmetic_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .rsp(rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Check every done beat at the edge that ends it.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			fsb.check_result(rsp);
	end

	// Mostly short gaps, a few long ones, some back to back.
	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 40)
			return 0;
		if (k < 92)
			return $urandom_range(1, 4);
		return $urandom_range(20, 400);
	endfunction

	// Random 32-bit operand: small values, extremes or full range.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0001;
			2: return rau_pkg::MIN_INT;
			3: return 32'd0;
			4, 5: return 32'($signed($urandom_range(0, 40)) - 20);
			6: return 32'($signed($urandom_range(0, 2000)) - 1000);
			default: return $urandom();
		endcase
	endfunction

	// Present one beat and hold it until accepted; drop start only across a gap.
	task automatic send_beat(rau_pkg::cmd_t c);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		fsb.note_command(c);
	endtask

	task automatic send_fields(logic [2:0] act, logic [31:0] an, logic [31:0] ad,
		logic [31:0] bn, logic [31:0] bd);
		rau_pkg::cmd_t c;
		c.action = act;
		c.a_num = an;
		c.a_den = ad;
		c.b_num = bn;
		c.b_den = bd;
		send_beat(c);
	endtask

	initial begin
		rau_pkg::cmd_t c;
		int            wait_cnt;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: every operation, extremes, sign handling, errors
		send_fields(rau_pkg::ACT_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
		send_fields(rau_pkg::ACT_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
		send_fields(rau_pkg::ACT_MUL, -32'sd3, 32'd4, 32'd2, -32'sd9);
		send_fields(rau_pkg::ACT_DIV, 32'd5, -32'sd6, -32'sd10, 32'd3);
		send_fields(rau_pkg::ACT_CMP, 32'd1, 32'd2, 32'd2, 32'd4);
		send_fields(rau_pkg::ACT_CMP, 32'd1, 32'd3, 32'd1, 32'd2);
		send_fields(rau_pkg::ACT_CMP, -32'sd1, -32'sd2, 32'd1, 32'd3);
		send_fields(rau_pkg::ACT_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF);
		send_fields(rau_pkg::ACT_MUL, 32'h7FFF_FFFF, 32'd1, 32'h8000_0001, 32'd1);
		send_fields(rau_pkg::ACT_MUL, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'h8000_0001);
		send_fields(rau_pkg::ACT_SUB, 32'h8000_0001, 32'd1, 32'h7FFF_FFFF, 32'd1);
		send_fields(rau_pkg::ACT_DIV, 32'h7FFF_FFFF, 32'd2, 32'h8000_0001, 32'd3);
		send_fields(rau_pkg::ACT_CMP, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFE,
			32'h7FFF_FFFD);
		send_fields(rau_pkg::ACT_MUL, 32'd0, 32'd7, 32'd5, -32'sd3);
		send_fields(rau_pkg::ACT_ADD, 32'd0, -32'sd5, 32'd0, 32'd9);
		send_fields(rau_pkg::ACT_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
		send_fields(rau_pkg::ACT_CMP, 32'd1, 32'd1, 32'd1, 32'd0);
		send_fields(rau_pkg::ACT_DIV, 32'd3, 32'd4, 32'd0, 32'd7);
		send_fields(rau_pkg::ACT_ADD, rau_pkg::MIN_INT, 32'd1, 32'd1, 32'd1);
		send_fields(rau_pkg::ACT_SUB, 32'd1, rau_pkg::MIN_INT, 32'd1, 32'd1);
		send_fields(rau_pkg::ACT_MUL, 32'd1, 32'd1, rau_pkg::MIN_INT, 32'd1);
		send_fields(rau_pkg::ACT_CMP, 32'd1, 32'd1, 32'd1, rau_pkg::MIN_INT);
		send_fields(3'd5, 32'd1, 32'd1, 32'd1, 32'd1);
		send_fields(3'd6, 32'd1, 32'd1, 32'd1, 32'd1);
		send_fields(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// random: mostly valid operations, some unused codes
		for (int i = 0; i < 450; i++) begin
			c.action = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			c.a_num = pick_word();
			c.a_den = pick_word();
			c.b_num = pick_word();
			c.b_den = pick_word();
			send_beat(c);
		end
		start <= 1'b0;
		// drain, then allow for the longest latency
		wait_cnt = 0;
		while (fsb.pending_q.size() != 0 && wait_cnt < 2000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (300) @(posedge clk);
		if (fsb.fail_cnt == 0 && fsb.pending_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Hold-off limit: generous multiple of the slowest run.
	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire
